@@ rtl/core/nmea_pkg.sv @@
`default_nettype none

package nmea_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;

   localparam logic [BYTE_W-1:0] CH_BEGIN = 8'h24;
   localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;

   localparam logic [BYTE_W-1:0] MIN_LENGTH_RESET = 8'd11;
   localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd82;
   localparam logic [BYTE_W-1:0] COUNT_MAX        = 8'hFF;

   typedef enum logic [0:0] {
      CSR_MIN_LENGTH = 1'b0,
      CSR_MAX_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_LENGTH   = 3'd1,
      ST_BEGIN    = 3'd2,
      ST_ENDINGS  = 3'd3,
      ST_PREFIX   = 3'd4,
      ST_CHECKSUM = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      HEX_NONE = 2'd0,
      HEX_ONE  = 2'd1,
      HEX_DONE = 2'd2,
      HEX_BAD  = 2'd3
   } hex_phase_type;

   // Bit 4 set means the byte is not a hex digit; otherwise bits 3:0 hold its value.
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [4:0] result;
      result = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         result = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         result = {1'b0, 4'(c[3:0] + 4'd9)};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/nmea_req_if.sv @@
`default_nettype none

interface nmea_req_if;
   import nmea_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nmea_rsp_if.sv @@
`default_nettype none

interface nmea_rsp_if;
   import nmea_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   computed_checksum;
   logic [BYTE_W-1:0]   received_checksum;

   modport source (output valid, output status, output computed_checksum,
                   output received_checksum, input ready);
   modport sink   (input valid, input status, input computed_checksum,
                   input received_checksum, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nmea_csr_if.sv @@
`default_nettype none

interface nmea_csr_if;
   import nmea_pkg::*;

   logic              valid;
   logic              ready;
   csr_index_type     index;
   logic [BYTE_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nmea_sentence_validator.sv @@
// NMEA 0183 sentence checker, one byte per transfer.
//
// req_chan carries the sentence bytes in order; last_byte marks the final
// byte. rsp_chan gives one status word per sentence, together with the
// computed XOR checksum and the checksum read after the '*'. csr_chan writes
// the minimum and maximum sentence length; it is always ready and should only
// be used between sentences.
//
// Each byte is captured in an input register, and from there it updates the
// per-sentence state and, on the last byte, loads the result register when
// that frees up. A result is thus valid once its last byte has passed both
// registers. One byte can transfer every cycle unless a last byte is waiting.
//
// When rsp_chan stalls, bytes that are not last still pass through; a last
// byte waits in the input register until the result register frees up, and
// req_chan drops ready behind it. Reset clears the sentence state, empties
// both registers and restores the length limits to 11 and 82.

`default_nettype none

module nmea_sentence_validator #(
   parameter int unsigned PREFIX_LEN = 5
) (
   input  wire logic       clock,
   input  wire logic       reset,
   nmea_req_if.sink        req_chan,
   nmea_rsp_if.source      rsp_chan,
   nmea_csr_if.sink        csr_chan
);
   import nmea_pkg::*;

   localparam logic [BYTE_W-1:0] PREFIX_LAST      = BYTE_W'(PREFIX_LEN);
   localparam logic [BYTE_W-1:0] COMMA_POS        = BYTE_W'(PREFIX_LEN + 1);
   localparam logic [BYTE_W-1:0] PREFIX_MIN_COUNT = BYTE_W'(PREFIX_LEN + 2);

   // Configuration.
   logic [BYTE_W-1:0] min_length_ff;
   logic [BYTE_W-1:0] max_length_ff;

   // Input register.
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;

   // Sentence state.
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic              star_ff, star_in;
   hex_phase_type     hex_phase_ff, hex_phase_in;
   logic [BYTE_W-1:0] value_ff, value_in;
   logic              begin_ff, begin_in;
   logic              prefix_ff, prefix_in;
   logic [BYTE_W-1:0] prev_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [BYTE_W-1:0] computed_ff, computed_in;
   logic [BYTE_W-1:0] received_ff, received_in;

   logic              out_free;
   logic              s1_move;
   logic              s1_fire;
   logic              req_fire;
   logic [4:0]        digit;
   logic              ends_ok;
   logic              prefix_good;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MIN_LENGTH: min_length_ff <= csr_chan.wdata;
            CSR_MAX_LENGTH: max_length_ff <= csr_chan.wdata;
            default: ;
         endcase
      end
   end

   // Only a last byte needs room in the result register.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move        = !s1_last_ff || out_free;
   assign s1_fire        = s1_valid_ff && s1_move;
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
   end

   assign digit = hex_value(s1_byte_ff);

   // Checksum digit tracking after the star.
   always_comb begin
      hex_phase_in = hex_phase_ff;
      value_in     = value_ff;
      if (star_ff) begin
         case (hex_phase_ff)
            HEX_NONE: begin
               if (!digit[4]) begin
                  value_in     = {4'd0, digit[3:0]};
                  hex_phase_in = HEX_ONE;
               end else begin
                  hex_phase_in = HEX_BAD;
               end
            end
            HEX_ONE: begin
               if (!digit[4]) begin
                  value_in = {value_ff[3:0], digit[3:0]};
               end
               hex_phase_in = HEX_DONE;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      begin_in  = begin_ff;
      prefix_in = prefix_ff;
      star_in   = star_ff;
      xor_in    = xor_ff;
      if (count_ff == '0) begin
         begin_in = (s1_byte_ff == CH_BEGIN);
      end
      if (count_ff >= 8'd1 && count_ff <= PREFIX_LAST &&
          (s1_byte_ff < CH_UPPER_A || s1_byte_ff > CH_UPPER_Z)) begin
         prefix_in = 1'b0;
      end
      if (count_ff == COMMA_POS && s1_byte_ff != CH_COMMA) begin
         prefix_in = 1'b0;
      end
      if (!star_ff) begin
         if (s1_byte_ff == CH_STAR) begin
            star_in = 1'b1;
         end else if (count_ff != '0) begin
            xor_in = xor_ff ^ s1_byte_ff;
         end
      end
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 8'd1;
   end

   assign ends_ok     = count_in >= 8'd2 && prev_ff == CH_CR && s1_byte_ff == CH_LF;
   assign prefix_good = prefix_in && count_in >= PREFIX_MIN_COUNT;
   assign computed_in = star_in ? xor_in : '0;
   assign received_in = (hex_phase_in == HEX_BAD) ? '0 : value_in;

   always_comb begin
      if (count_in > max_length_ff || count_in < min_length_ff) begin
         status_in = ST_LENGTH;
      end else if (!begin_in) begin
         status_in = ST_BEGIN;
      end else if (!ends_ok) begin
         status_in = ST_ENDINGS;
      end else if (!prefix_good) begin
         status_in = ST_PREFIX;
      end else if (received_in == '0 || received_in != computed_in) begin
         status_in = ST_CHECKSUM;
      end else begin
         status_in = ST_OK;
      end
   end

   // The last byte clears everything so the next byte opens a new sentence.
   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_last_ff)) begin
         count_ff     <= '0;
         xor_ff       <= '0;
         star_ff      <= 1'b0;
         hex_phase_ff <= HEX_NONE;
         value_ff     <= '0;
         begin_ff     <= 1'b0;
         prefix_ff    <= 1'b1;
         prev_ff      <= '0;
      end else if (s1_fire) begin
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         star_ff      <= star_in;
         hex_phase_ff <= hex_phase_in;
         value_ff     <= value_in;
         begin_ff     <= begin_in;
         prefix_ff    <= prefix_in;
         prev_ff      <= s1_byte_ff;
      end
   end

   assign rsp_valid_in = (s1_fire && s1_last_ff) || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         status_ff   <= status_in;
         computed_ff <= computed_in;
         received_ff <= received_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = status_ff;
   assign rsp_chan.computed_checksum = computed_ff;
   assign rsp_chan.received_checksum = received_ff;

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result appeared without a last byte");

   a_ok_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_OK |->
         computed_ff == received_ff && received_ff != '0)
      else $error("ok status with bad checksum");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> count_ff == '0 && !star_ff)
      else $error("sentence state not cleared");

   a_digits_after_star: assert property (@(posedge clock) disable iff (reset)
      hex_phase_ff != HEX_NONE |-> star_ff)
      else $error("hex digits tracked before star");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import nmea_pkg::*;

   localparam int PREFIX_LEN    = 5;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 250;

   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] computed;
      logic [BYTE_W-1:0] received;
   } sentence_verdict_type;

   typedef struct {
      string             text;
      bit                typed;
      status_type        status;
      logic [BYTE_W-1:0] computed;
      logic [BYTE_W-1:0] received;
   } pattern_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nmea_req_if req_if ();
   nmea_rsp_if rsp_if ();
   nmea_csr_if csr_if ();

   nmea_sentence_validator #(.PREFIX_LEN(PREFIX_LEN)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Short fixed sentences; the first two have results that are easy to read off by hand.
   pattern_row_type patterns[3] = '{
      '{"$GPGGA,*7A\015\012", 1'b1, ST_OK, 8'h7A, 8'h7A},
      '{"\377", 1'b1, ST_LENGTH, 8'h00, 8'h00},
      '{"$gpgga,*7a\015\012", 1'b0, ST_OK, 8'h00, 8'h00}
   };

   // Shadow copy of the length limits and of the per-sentence scan state.
   logic [BYTE_W-1:0] len_min;
   logic [BYTE_W-1:0] len_max;
   logic [BYTE_W-1:0] byte_cnt;
   logic [BYTE_W-1:0] xor_acc;
   logic              star_found;
   hex_phase_type     hex_phase;
   logic [BYTE_W-1:0] hex_acc;
   logic              dollar_ok;
   logic              talker_ok;
   logic [BYTE_W-1:0] prior_byte;

   sentence_verdict_type awaited_verdicts[$];
   logic [BYTE_W-1:0]    frame_q[$];

   bit src_idle_on      = 1'b1;
   bit rsp_idle_on      = 1'b1;
   bit rsp_hold_pending = 1'b0;

   int mismatch_count   = 0;
   int verdicts_checked = 0;
   int bytes_sent       = 0;
   int sentences_sent   = 0;
   int limit_settings   = 1;
   int long_holds       = 0;

   function automatic int hex_digit(input logic [BYTE_W-1:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) return 8'("0" + nibble);
      return $urandom_range(0, 1) ? 8'("a" + nibble - 10) : 8'("A" + nibble - 10);
   endfunction

   function automatic void append_byte(input logic [BYTE_W-1:0] c);
      frame_q.insert(frame_q.size(), c);
   endfunction

   function automatic void clear_sentence();
      byte_cnt   = '0;
      xor_acc    = '0;
      star_found = 1'b0;
      hex_phase  = HEX_NONE;
      hex_acc    = '0;
      dollar_ok  = 1'b0;
      talker_ok  = 1'b1;
      prior_byte = '0;
   endfunction

   // Advances the scan state by one accepted byte; on the last byte it queues the verdict.
   task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic is_last);
      int                   pos;
      int                   d;
      logic                 prefix_good;
      logic                 ends_ok;
      logic [BYTE_W-1:0]    computed;
      logic [BYTE_W-1:0]    received;
      status_type           verdict;
      sentence_verdict_type entry;
      pos = byte_cnt;
      if (pos == 0) dollar_ok = (b == CH_BEGIN);
      if (pos >= 1 && pos <= PREFIX_LEN && (b < CH_UPPER_A || b > CH_UPPER_Z)) begin
         talker_ok = 1'b0;
      end
      if (pos == PREFIX_LEN + 1 && b != CH_COMMA) talker_ok = 1'b0;
      if (!star_found) begin
         if (b == CH_STAR) star_found = 1'b1;
         else if (pos >= 1) xor_acc ^= b;
      end else begin
         d = hex_digit(b);
         case (hex_phase)
            HEX_NONE: begin
               if (d >= 0) begin
                  hex_acc   = 8'(d);
                  hex_phase = HEX_ONE;
               end else begin
                  hex_phase = HEX_BAD;
               end
            end
            HEX_ONE: begin
               if (d >= 0) hex_acc = {hex_acc[3:0], 4'(d)};
               hex_phase = HEX_DONE;
            end
            default: ;
         endcase
      end
      if (byte_cnt != COUNT_MAX) byte_cnt++;
      if (!is_last) begin
         prior_byte = b;
         return;
      end
      computed    = star_found ? xor_acc : 8'h00;
      received    = (hex_phase == HEX_BAD) ? 8'h00 : hex_acc;
      prefix_good = talker_ok && (byte_cnt >= PREFIX_LEN + 2);
      ends_ok     = (byte_cnt >= 2) && (prior_byte == CH_CR) && (b == CH_LF);
      if (byte_cnt > len_max || byte_cnt < len_min) verdict = ST_LENGTH;
      else if (!dollar_ok) verdict = ST_BEGIN;
      else if (!ends_ok) verdict = ST_ENDINGS;
      else if (!prefix_good) verdict = ST_PREFIX;
      else if (received == 8'h00 || received != computed) verdict = ST_CHECKSUM;
      else verdict = ST_OK;
      entry = '{verdict, computed, received};
      awaited_verdicts.insert(awaited_verdicts.size(), entry);
      clear_sentence();
   endtask

   // Mostly well-formed sentences with random content, then, unless clean is set, some damage on top.
   function automatic void build_sentence(input int body_lo, input int body_hi, input bit clean);
      int                variant;
      int                idx;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] c;
      frame_q.delete();
      if (!clean && $urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 14)) append_byte(8'($urandom));
         return;
      end
      append_byte(CH_BEGIN);
      repeat (PREFIX_LEN) append_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
      append_byte(CH_COMMA);
      repeat ($urandom_range(body_lo, body_hi)) begin
         c = 8'($urandom_range(8'h20, 8'h7E));
         append_byte(c == CH_STAR ? CH_COMMA : c);
      end
      sum = 8'h00;
      for (int i = 1; i < frame_q.size(); i++) sum ^= frame_q[i];
      // 0-4 correct sum, 5 wrong, 6 zero, 7 one digit, 8 non-hex after star, 9 no star.
      variant = clean ? 0 : $urandom_range(0, 9);
      if (variant != 9) append_byte(CH_STAR);
      if (variant == 5) sum ^= 8'($urandom_range(1, 255));
      if (variant == 6) sum = 8'h00;
      if (variant <= 6) begin
         append_byte(hex_char(sum[7:4]));
         append_byte(hex_char(sum[3:0]));
      end else if (variant == 7) begin
         append_byte(hex_char(sum[3:0]));
      end else if (variant == 8) begin
         do c = 8'($urandom); while (hex_digit(c) >= 0);
         append_byte(c);
      end
      if (!clean && $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      if (clean || $urandom_range(0, 9) != 0) begin
         append_byte(CH_CR);
         append_byte(CH_LF);
      end else begin
         case ($urandom_range(0, 2))
            0: append_byte(CH_LF);
            1: begin
               append_byte(CH_LF);
               append_byte(CH_CR);
            end
            default: append_byte(8'($urandom));
         endcase
      end
      if (!clean && $urandom_range(0, 6) == 0) begin
         idx = $urandom_range(0, frame_q.size() - 1);
         frame_q[idx] = 8'($urandom);
      end
      if (!clean && $urandom_range(0, 11) == 0) begin
         idx = $urandom_range(1, frame_q.size());
         while (frame_q.size() > idx) void'(frame_q.pop_back());
      end
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic is_last);
      int gap;
      gap = src_idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= value;
      req_if.last_byte <= is_last;
      do @(posedge clock); while (!req_if.ready);
      scan_byte(value, is_last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      sentences_sent++;
   endtask

   task automatic run_random(input int quota, input bit allow_long);
      int stop_at;
      int pick;
      stop_at = bytes_sent + quota;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 29);
         if (allow_long && pick == 0) build_sentence(200, 280, 1'b0);
         else if (pick < 4) build_sentence(40, 110, 1'b0);
         else build_sentence(0, 30, 1'b0);
         src_idle_on = ($urandom_range(0, 3) != 0);
         send_frame();
      end
   endtask

   // Waits until every queued verdict has come back, then lets the pipeline settle.
   task automatic drain_verdicts();
      req_if.valid <= 1'b0;
      while (awaited_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_MIN_LENGTH) len_min = value;
      else len_max = value;
   endtask

   task automatic set_limits(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
      write_limit(CSR_MIN_LENGTH, lo);
      write_limit(CSR_MAX_LENGTH, hi);
      csr_if.valid <= 1'b0;
      limit_settings++;
   endtask

   initial begin : stimulus
      logic [BYTE_W-1:0] lo;
      clear_sentence();
      len_min = MIN_LENGTH_RESET;
      len_max = MAX_LENGTH_RESET;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.last_byte <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= CSR_MIN_LENGTH;
      csr_if.wdata     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (patterns[r]) begin
         for (int k = 0; k < patterns[r].text.len(); k++) begin
            send_byte(patterns[r].text[k], k == patterns[r].text.len() - 1);
         end
         if (patterns[r].typed) begin
            awaited_verdicts[$] = '{patterns[r].status, patterns[r].computed,
                                    patterns[r].received};
         end
      end
      run_random(350, 1'b0);

      // Hold the result side for a long stretch while short sentences keep coming.
      drain_verdicts();
      src_idle_on = 1'b0;
      rsp_hold_pending = 1'b1;
      repeat (12) begin
         build_sentence(0, 3, 1'b0);
         send_frame();
      end
      drain_verdicts();

      set_limits(8'd0, 8'd254);
      frame_q = '{CH_BEGIN, CH_CR, CH_LF};
      send_frame();
      run_random(350, 1'b1);
      drain_verdicts();

      set_limits(8'd254, 8'd254);
      repeat (2) begin
         build_sentence(242, 242, 1'b1);
         send_frame();
      end
      run_random(50, 1'b0);
      drain_verdicts();

      set_limits(8'd0, 8'd1);
      repeat (4) begin
         frame_q = '{CH_BEGIN};
         send_frame();
      end
      run_random(150, 1'b0);
      drain_verdicts();

      lo = 8'($urandom_range(0, 20));
      set_limits(lo, 8'($urandom_range(lo == 0 ? 1 : lo, 120)));
      run_random(300, 1'b1);
      drain_verdicts();

      set_limits(8'd12, 8'd40);
      run_random(250, 1'b0);
      drain_verdicts();

      $display("Checked %0d sentence results from %0d bytes in %0d sentences over %0d limit settings,",
               verdicts_checked, bytes_sent, sentences_sent, limit_settings);
      $display("with random idles on both sides and %0d long stall(s) of the result side.",
               long_holds);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : rsp_drain
      int stall;
      rsp_if.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) rsp_idle_on = !rsp_idle_on;
         stall = rsp_idle_on ? $urandom_range(0, 18) : 0;
         if (rsp_hold_pending) begin
            stall += LONG_HOLD;
            rsp_hold_pending = 1'b0;
            long_holds++;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   always @(posedge clock) begin : verdict_check
      sentence_verdict_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_verdicts.size() == 0) begin
            $display("%0t: result with none expected: status %0d computed %h received %h",
                     $time, rsp_if.status, rsp_if.computed_checksum, rsp_if.received_checksum);
            mismatch_count++;
         end else begin
            want = awaited_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_if.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_if.status);
               mismatch_count++;
            end
            if (rsp_if.computed_checksum !== want.computed) begin
               $display("%0t: computed checksum expected %h actual %h",
                        $time, want.computed, rsp_if.computed_checksum);
               mismatch_count++;
            end
            if (rsp_if.received_checksum !== want.received) begin
               $display("%0t: received checksum expected %h actual %h",
                        $time, want.received, rsp_if.received_checksum);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #3_000_000;
      $display("%0t: run did not finish, %0d results still expected",
               $time, awaited_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/nmea_pkg.sv
rtl/core/nmea_req_if.sv
rtl/core/nmea_rsp_if.sv
rtl/core/nmea_csr_if.sv
rtl/core/nmea_sentence_validator.sv
tb/testbench.sv
